/* design/dqs_pkg.sv */
package dqs_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned IN_USER_W   = 8;
  localparam int unsigned OUT_DATA_W  = 16;
  localparam int unsigned OUT_USER_W  = 8;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic srch_step;
    logic load_out;
  } dqs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_search;
    logic srch_done;
  } dqs_sts_t;

endpackage

/* design/double_ended_queue_search.sv */
// pushes, pops and unused ops go from input transfer through execute to the result;
// a search steps through the stored entries from the front until a match or the end;
// the search compares one stored entry per cycle
// through the single read port of the slot memory
// one item at a time: the next item is taken only once its result is registered
// reset (async, active low) empties the queue and clears front slot and output valid
module double_ended_queue_search
  import dqs_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // item_value[31:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,  // op[2:0], zero fill
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // position[4:0], occupancy[9:5], zero fill
  output logic [OUT_USER_W-1:0] m_axis_tuser   // status[1:0], zero fill
);

  dqs_cmd_t            cmd;
  dqs_sts_t            sts;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [OCC_W-1:0]    occupancy;

  dqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dqs_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (s_axis_tuser[OP_W-1:0]),
    .item_value_i (s_axis_tdata[ITEM_W-1:0]),
    .status_o     (status),
    .position_o   (position),
    .occupancy_o  (occupancy)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - POS_W - OCC_W){1'b0}}, occupancy, position};
  assign m_axis_tuser = {{(OUT_USER_W - STATUS_W){1'b0}}, status};

  // a taken item blocks the input until its result is registered
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // the output register is never reloaded while it holds an untaken result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("pending result overwritten");

  // a failed operation never reports a position
  a_pos_only_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status != ST_OK) |-> position == '0)
    else $error("position set on a failed operation");

  // a refused push only happens on a full queue
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == ST_FULL) |-> occupancy == OCC_W'(DEPTH))
    else $error("full status with queue not full");

endmodule

/* design/dqs_ram.sv */
module dqs_ram
  #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/dqs_ctrl.sv */
module dqs_ctrl
  import dqs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dqs_sts_t sts_i,
  output dqs_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.go_search ? S_SRCH : S_DONE;
      end
      S_SRCH: begin
        cmd_o.srch_step = 1'b1;
        if (sts_i.srch_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // wait until the output register can take the result
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* design/dqs_datapath.sv */
module dqs_datapath
  import dqs_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dqs_cmd_t            cmd_i,
  output dqs_sts_t            sts_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [ITEM_W-1:0]   item_value_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [POS_W-1:0]    position_o,
  output logic [OCC_W-1:0]    occupancy_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = IW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [OP_W-1:0]       op_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [IW-1:0]         front_q, front_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         k_q, k_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [CW-1:0]         cmp_k_q;
  logic [STATUS_W-1:0]   res_status_q, res_status_d;
  logic [CW-1:0]         res_pos_q, res_pos_d;
  logic [STATUS_W-1:0]   out_status_q;
  logic [POS_W-1:0]      out_pos_q;
  logic [OCC_W-1:0]      out_occ_q;

  logic [63:0]           item_ext;
  logic                  full, empty;
  logic [SW-1:0]         sum_back, sum_srch;
  logic [IW-1:0]         slot_back, slot_srch, front_dec, front_inc;
  logic                  ram_we, ram_re;
  logic [IW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                  found, miss;

  assign item_ext = {32'd0, item_value_i};

  assign full  = count_q == DEPTH_C;
  assign empty = count_q == '0;

  // ring slot arithmetic, sums stay below twice the depth
  assign sum_back  = {1'b0, front_q} + {1'b0, count_q[IW-1:0]};
  assign sum_srch  = {1'b0, front_q} + {1'b0, k_q[IW-1:0]};
  assign slot_back = (sum_back >= DEPTH_S) ? IW'(sum_back - DEPTH_S) : sum_back[IW-1:0];
  assign slot_srch = (sum_srch >= DEPTH_S) ? IW'(sum_srch - DEPTH_S) : sum_srch[IW-1:0];
  assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - 1'b1;
  assign front_inc = (front_q == LAST_SLOT) ? '0 : front_q + 1'b1;

  assign found = cmp_vld_q && (ram_rdata == val_q);
  assign miss  = !cmp_vld_q && (k_q >= count_q);

  assign sts_o.go_search = (op_q == OP_SEARCH) && !empty;
  assign sts_o.srch_done = found || miss;

  assign ram_re = cmd_i.srch_step && (k_q < count_q);

  always_comb begin
    front_d      = front_q;
    count_d      = count_q;
    k_d          = k_q;
    cmp_vld_d    = cmp_vld_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    ram_we       = 1'b0;
    ram_waddr    = slot_back;
    if (cmd_i.exec) begin
      res_status_d = ST_OK;
      res_pos_d    = '0;
      k_d          = '0;
      cmp_vld_d    = 1'b0;
      unique case (op_q)
        OP_PUSH_FRONT: begin
          if (full) begin
            res_status_d = ST_FULL;
          end else begin
            front_d   = front_dec;
            ram_we    = 1'b1;
            ram_waddr = front_dec;
            count_d   = count_q + 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            res_status_d = ST_FULL;
          end else begin
            ram_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            res_status_d = ST_EMPTY;
          end else begin
            front_d = front_inc;
            count_d = count_q - 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            res_status_d = ST_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        OP_SEARCH: begin
          if (empty) begin
            res_status_d = ST_EMPTY;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.srch_step) begin
      // at most one read issued and one compare per cycle
      cmp_vld_d = ram_re;
      if (ram_re) begin
        k_d = k_q + 1'b1;
      end
      if (found) begin
        res_status_d = ST_OK;
        res_pos_d    = cmp_k_q + 1'b1;
      end else if (miss) begin
        res_status_d = ST_NOT_FOUND;
        res_pos_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      count_q   <= '0;
      k_q       <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      front_q   <= front_d;
      count_q   <= count_d;
      k_q       <= k_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= op_i;
      val_q <= item_ext[DATA_WIDTH-1:0];
    end
    if (cmd_i.srch_step) begin
      cmp_k_q <= k_q;
    end
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_pos_q    <= POS_W'(res_pos_q);
      out_occ_q    <= OCC_W'(count_q);
    end
  end

  dqs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (val_q),
    .re_i    (ram_re),
    .raddr_i (slot_srch),
    .rdata_o (ram_rdata)
  );

  assign status_o    = out_status_q;
  assign position_o  = out_pos_q;
  assign occupancy_o = out_occ_q;

endmodule
